// File: sv/upf_pkg.sv
package upf_pkg;

	localparam int WORD_BITS = 32;
	localparam int JOB_DEPTH = 4;
	localparam int JOB_AW = $clog2(JOB_DEPTH);

	typedef logic signed [WORD_BITS-1:0] word_t;

	localparam word_t WMAX = word_t'(32'h7FFF_FFFF);
	localparam word_t WMIN = word_t'(32'h8000_0000);
	localparam word_t ONE = word_t'(32'h0001_0000);

	// Q30 fixed point for the sine and cosine series
	localparam logic [30:0] Q30 = 31'h4000_0000;
	localparam logic [33:0] TWO_PI_Q30 = 34'd6746518852;

	// reciprocal constants for exact floor division of values below 2^30
	localparam logic [32:0] MG_72 = 33'(((64'd1 << 38) + 64'd71) / 64'd72);
	localparam logic [32:0] MG_42 = 33'(((64'd1 << 37) + 64'd41) / 64'd42);
	localparam logic [32:0] MG_20 = 33'(((64'd1 << 36) + 64'd19) / 64'd20);
	localparam logic [32:0] MG_6 = 33'(((64'd1 << 34) + 64'd5) / 64'd6);
	localparam logic [32:0] MG_90 = 33'(((64'd1 << 38) + 64'd89) / 64'd90);
	localparam logic [32:0] MG_56 = 33'(((64'd1 << 37) + 64'd55) / 64'd56);
	localparam logic [32:0] MG_30 = 33'(((64'd1 << 36) + 64'd29) / 64'd30);
	localparam logic [32:0] MG_12 = 33'(((64'd1 << 35) + 64'd11) / 64'd12);

	typedef enum logic [2:0] {
		REG_GAIN_CUBIC = 3'd0,
		REG_GAIN_SQUARE_TRIPLE = 3'd1,
		REG_ANGULAR_RATE_LIMIT = 3'd2,
		REG_TARGET_SPEED = 3'd3,
		REG_REVERSE_MODE = 3'd4
	} cfg_reg_e;

	typedef struct packed {
		word_t lateral_error;
		logic [15:0] path_heading;
		logic [15:0] robot_heading;
		word_t path_curvature;
		word_t curvature_slope;
		word_t velocity_x;
		word_t velocity_y;
		logic [16:0] speed_factor;
	} in_item_t;

	typedef struct packed {
		word_t angular_rate;
		word_t linear_speed;
		logic status;
	} out_item_t;

	typedef struct packed {
		logic [30:0] gain_cubic;
		logic [30:0] gain_square_triple;
		logic [30:0] angular_rate_limit;
		logic [30:0] target_speed;
		logic reverse_mode;
	} cfg_t;

	// classified item handed from front to back
	typedef struct packed {
		word_t d;
		word_t c;
		word_t dcs;
		word_t vx;
		word_t vy;
		word_t lin;
		logic [15:0] e;
		logic rev;
	} job_t;

	typedef struct packed {
		logic neg;
		logic [63:0] p;
	} mulp_t;

	typedef struct packed {
		logic neg;
		logic [31:0] n;
		logic [31:0] dm;
		logic [32:0] r;
		logic [47:0] q;
	} divs_t;

	function automatic logic [31:0] mag(input word_t x);
		return x[31] ? 32'(-x) : 32'(x);
	endfunction

	function automatic word_t sat34(input logic [33:0] x);
		if (!x[33] && x[32:31] != 2'b00) return WMAX;
		if (x[33] && x[32:31] != 2'b11) return WMIN;
		return word_t'(x[31:0]);
	endfunction

	function automatic logic [33:0] sx34(input word_t x);
		return {{2{x[31]}}, x};
	endfunction

	// magnitude product, rounded and saturated in the following stage
	function automatic mulp_t fmul_p(input word_t a, input word_t b);
		mulp_t m;
		m.neg = a[31] ^ b[31];
		m.p = 64'(mag(a)) * 64'(mag(b));
		return m;
	endfunction

	function automatic word_t fmul_fin(input mulp_t m);
		logic [63:0] lr;
		logic [47:0] v;
		lr = m.p + 64'd32768;
		v = lr[63:16];
		if (m.neg) begin
			if (v > 48'h0000_8000_0000) return WMIN;
			return word_t'(~v[31:0] + 32'd1);
		end
		if (v > 48'h0000_7FFF_FFFF) return WMAX;
		return word_t'(v[31:0]);
	endfunction

	function automatic divs_t div_init(input word_t a, input word_t b);
		divs_t s;
		s.neg = a[31] ^ b[31];
		s.n = mag(a);
		s.dm = mag(b);
		s.r = '0;
		s.q = '0;
		return s;
	endfunction

	// one restoring step on dividend bit i of n * 2^16
	function automatic divs_t div_step(input divs_t s, input int i);
		logic [47:0] nn;
		logic [32:0] r2;
		nn = {s.n, 16'd0};
		r2 = {s.r[31:0], nn[i]};
		s.q = {s.q[46:0], 1'b0};
		if (r2 >= {1'b0, s.dm}) begin
			r2 = r2 - {1'b0, s.dm};
			s.q[0] = 1'b1;
		end
		s.r = r2;
		return s;
	endfunction

	function automatic word_t div_fin(input divs_t s);
		if (s.n == 32'd0) return '0;
		if (s.neg) begin
			if (s.q > 48'h0000_8000_0000) return WMIN;
			return word_t'(~s.q[31:0] + 32'd1);
		end
		if (s.q > 48'h0000_7FFF_FFFF) return WMAX;
		return word_t'(s.q[31:0]);
	endfunction

	function automatic logic [29:0] cdiv(input logic [29:0] x, input logic [32:0] m,
			input int sh);
		logic [63:0] p;
		p = 64'(x) * 64'(m);
		return 30'(p >> sh);
	endfunction

	function automatic word_t q30_to_fix(input logic [30:0] m, input logic neg);
		logic [31:0] v;
		v = (32'(m) + 32'd8192) >> 14;
		return neg ? word_t'(-v) : word_t'(v);
	endfunction

endpackage

// File: sv/upf_job_fifo.sv
module upf_job_fifo import upf_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input job_t wr_job,
	input logic pop,
	output logic empty,
	output job_t rd_job
);

	job_t mem_q [JOB_DEPTH];
	logic [JOB_AW-1:0] wr_q, rd_q;
	logic [JOB_AW:0] cnt_q;
	logic do_push, do_pop;

	assign full = (cnt_q == (JOB_AW+1)'(JOB_DEPTH));
	assign empty = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rd_job = mem_q[rd_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + 1'b1;
			if (do_pop) rd_q <= rd_q + 1'b1;
			if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= wr_job;
	end

endmodule

// File: sv/upf_front.sv
module upf_front import upf_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input in_item_t sample,
	input cfg_t cfg,
	output logic job_push,
	input logic job_full,
	output job_t job
);

	logic vld_s1;
	job_t job_s1;
	job_t job_d;
	logic take;
	logic [16:0] f;
	logic [47:0] lp;
	word_t lin;

	assign full = vld_s1 && job_full;
	assign take = push && !full;
	assign job_push = vld_s1;
	assign job = job_s1;

	// heading error, reverse handling and speed command
	always_comb begin
		f = (sample.speed_factor > 17'd65536) ? 17'd65536 : sample.speed_factor;
		lp = 48'(cfg.target_speed) * 48'(f) + 48'd32768;
		lin = word_t'(lp[47:16]);
		job_d.d = sample.lateral_error;
		job_d.c = sample.path_curvature;
		job_d.dcs = sample.curvature_slope;
		job_d.vx = sample.velocity_x;
		job_d.vy = sample.velocity_y;
		job_d.e = sample.robot_heading - sample.path_heading;
		job_d.rev = cfg.reverse_mode;
		job_d.lin = lin;
		if (cfg.reverse_mode) begin
			job_d.d = (sample.lateral_error == WMIN) ? WMAX : -sample.lateral_error;
			job_d.e = job_d.e + 16'h8000;
			job_d.lin = -lin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!full) begin
			vld_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (take) job_s1 <= job_d;
	end

endmodule

// File: sv/upf_back.sv
module upf_back import upf_pkg::*; (
	input logic clk,
	input logic arst_n,
	input cfg_t cfg,
	input logic job_empty,
	input job_t job,
	output logic job_pop,
	output logic empty,
	input logic pop,
	output out_item_t result
);

	// stage map of the law pipeline
	localparam int ST_SQRT = 2;
	localparam int SQRT_STEPS = 32;
	localparam int ST_VM = ST_SQRT + SQRT_STEPS;
	localparam int ST_DIVA = ST_VM + 2;
	localparam int DIV_STEPS = 48;
	localparam int ST_DIVA_FIN = ST_DIVA + DIV_STEPS;
	localparam int ST_GAIN = ST_DIVA_FIN + 1;
	localparam int ST_DIVB = ST_GAIN + 7;
	localparam int ST_DIVB_FIN = ST_DIVB + DIV_STEPS;
	localparam int NSTG = ST_DIVB_FIN + 2;

	typedef struct packed {
		word_t d, c, dcs, vx, vy, lin;
		logic [15:0] e;
		logic rev;
		logic sing;
		logic [63:0] sqx, sqy, sqn, sqres;
		word_t one_dc;
		logic [1:0] quad;
		logic rneg;
		logic [29:0] x, x2;
		logic [30:0] ts, tc;
		logic [63:0] ps, pc;
		word_t sn, cs, sn2, cs2, scs, ddcs, m_in, vmcs;
		word_t u1, tn, iq, x2v, ku1, kau1, csn, a1, a2, u2, inner, t1n, ui, t1;
		mulp_t m0, m1, m2, m3;
		divs_t dv0, dv1, dv2;
	} ctx_t;

	function automatic ctx_t stage_op(input int idx, input ctx_t a, input cfg_t cf);
		ctx_t o;
		logic [15:0] es, r;
		logic [63:0] bv, tt;
		logic [30:0] s0, c0;
		word_t vmv, au1, k1, k2;
		o = a;
		k1 = word_t'({1'b0, cf.gain_cubic});
		k2 = word_t'({1'b0, cf.gain_square_triple});
		// squares, d*c and angle reduction
		if (idx == 0) begin
			o.sqx = 64'(mag(a.vx)) * 64'(mag(a.vx));
			o.sqy = 64'(mag(a.vy)) * 64'(mag(a.vy));
			o.m0 = fmul_p(a.d, a.c);
			es = a.e + 16'd8192;
			o.quad = es[15:14];
			r = a.e - {es[15:14], 14'd0};
			o.rneg = r[15];
			if (r[15]) r = 16'd0 - r;
			o.x = 30'((64'(r) * 64'(TWO_PI_Q30)) >> 16);
		end
		if (idx == 1) begin
			o.sqn = a.sqx + a.sqy;
			o.sqres = '0;
			o.one_dc = sat34(sx34(ONE) - sx34(fmul_fin(a.m0)));
			o.sing = o.one_dc[31] || (o.one_dc == '0);
			o.x2 = 30'((64'(a.x) * 64'(a.x)) >> 30);
		end
		// sine and cosine series
		if (idx == 2) begin
			o.ts = Q30 - {1'b0, cdiv(a.x2, MG_72, 38)};
			o.tc = Q30 - {1'b0, cdiv(a.x2, MG_90, 38)};
		end
		if (idx == 3 || idx == 5 || idx == 7) begin
			o.ps = 64'(a.x2) * 64'(a.ts);
			o.pc = 64'(a.x2) * 64'(a.tc);
		end
		if (idx == 4) begin
			o.ts = Q30 - {1'b0, cdiv(a.ps[59:30], MG_42, 37)};
			o.tc = Q30 - {1'b0, cdiv(a.pc[59:30], MG_56, 37)};
		end
		if (idx == 6) begin
			o.ts = Q30 - {1'b0, cdiv(a.ps[59:30], MG_20, 36)};
			o.tc = Q30 - {1'b0, cdiv(a.pc[59:30], MG_30, 36)};
		end
		if (idx == 8) begin
			o.ts = Q30 - {1'b0, cdiv(a.ps[59:30], MG_6, 34)};
			o.tc = Q30 - {1'b0, cdiv(a.pc[59:30], MG_12, 35)};
		end
		if (idx == 9) begin
			o.ps = 64'(a.x) * 64'(a.ts);
			o.pc = 64'(a.x2) * 64'(a.tc);
		end
		if (idx == 10) begin
			s0 = {1'b0, a.ps[59:30]};
			c0 = Q30 - {1'b0, a.pc[60:31]};
			unique case (a.quad)
				2'd0: begin
					o.sn = q30_to_fix(s0, a.rneg);
					o.cs = q30_to_fix(c0, 1'b0);
				end
				2'd1: begin
					o.sn = q30_to_fix(c0, 1'b0);
					o.cs = q30_to_fix(s0, !a.rneg);
				end
				2'd2: begin
					o.sn = q30_to_fix(s0, !a.rneg);
					o.cs = q30_to_fix(c0, 1'b1);
				end
				2'd3: begin
					o.sn = q30_to_fix(c0, 1'b1);
					o.cs = q30_to_fix(s0, a.rneg);
				end
			endcase
		end
		// trig products and curvature slope term
		if (idx == 11) begin
			o.m0 = fmul_p(a.sn, a.sn);
			o.m1 = fmul_p(a.cs, a.cs);
			o.m2 = fmul_p(a.sn, a.cs);
			o.m3 = fmul_p(a.d, a.dcs);
		end
		if (idx == 12) begin
			o.sn2 = fmul_fin(a.m0);
			o.cs2 = fmul_fin(a.m1);
			o.scs = fmul_fin(a.m2);
			o.ddcs = fmul_fin(a.m3);
		end
		if (idx == 13) o.m0 = fmul_p(a.ddcs, a.scs);
		if (idx == 14) o.m_in = fmul_fin(a.m0);
		// square root of the speed, one result bit per stage
		if (idx >= ST_SQRT && idx < ST_SQRT + SQRT_STEPS) begin
			bv = 64'd1 << (62 - 2 * (idx - ST_SQRT));
			tt = a.sqres + bv;
			if (a.sqn >= tt) begin
				o.sqn = a.sqn - tt;
				o.sqres = (a.sqres >> 1) + bv;
			end else begin
				o.sqres = a.sqres >> 1;
			end
		end
		if (idx == ST_VM) begin
			vmv = (a.sqres[63:31] != '0) ? WMAX : word_t'(a.sqres[31:0]);
			if (a.rev) vmv = -vmv;
			o.m0 = fmul_p(vmv, a.cs);
		end
		if (idx == ST_VM + 1) o.vmcs = fmul_fin(a.m0);
		// first division level: u1, tan, slope term
		if (idx >= ST_DIVA && idx < ST_DIVA_FIN) begin
			if (idx == ST_DIVA) begin
				o.dv0 = div_init(a.vmcs, a.one_dc);
				o.dv1 = div_init(a.sn, a.cs);
				o.dv2 = div_init(a.m_in, a.one_dc);
			end
			o.dv0 = div_step(o.dv0, DIV_STEPS - 1 - (idx - ST_DIVA));
			o.dv1 = div_step(o.dv1, DIV_STEPS - 1 - (idx - ST_DIVA));
			o.dv2 = div_step(o.dv2, DIV_STEPS - 1 - (idx - ST_DIVA));
		end
		if (idx == ST_DIVA_FIN) begin
			o.u1 = div_fin(a.dv0);
			o.tn = div_fin(a.dv1);
			o.iq = div_fin(a.dv2);
		end
		// gains and heading terms
		if (idx == ST_GAIN) begin
			au1 = (a.u1 == WMIN) ? WMAX : (a.u1[31] ? -a.u1 : a.u1);
			o.m0 = fmul_p(a.one_dc, a.tn);
			o.m1 = fmul_p(k1, a.u1);
			o.m2 = fmul_p(k2, au1);
			o.m3 = fmul_p(a.c, sat34(sx34(ONE) + sx34(a.sn2)));
		end
		if (idx == ST_GAIN + 1) begin
			o.x2v = fmul_fin(a.m0);
			o.ku1 = fmul_fin(a.m1);
			o.kau1 = fmul_fin(a.m2);
			o.csn = fmul_fin(a.m3);
		end
		if (idx == ST_GAIN + 2) begin
			o.m0 = fmul_p(a.ku1, a.d);
			o.m1 = fmul_p(a.kau1, a.x2v);
		end
		if (idx == ST_GAIN + 3) begin
			o.a1 = fmul_fin(a.m0);
			o.a2 = fmul_fin(a.m1);
		end
		if (idx == ST_GAIN + 4) begin
			o.u2 = sat34(34'd0 - sx34(a.a1) - sx34(a.a2));
			o.inner = sat34(sx34(a.csn) + sx34(a.iq));
		end
		if (idx == ST_GAIN + 5) begin
			o.m0 = fmul_p(a.u2, a.cs2);
			o.m1 = fmul_p(a.u1, a.inner);
		end
		if (idx == ST_GAIN + 6) begin
			o.t1n = fmul_fin(a.m0);
			o.ui = fmul_fin(a.m1);
		end
		// second division level
		if (idx >= ST_DIVB && idx < ST_DIVB_FIN) begin
			if (idx == ST_DIVB) o.dv0 = div_init(a.t1n, a.one_dc);
			o.dv0 = div_step(o.dv0, DIV_STEPS - 1 - (idx - ST_DIVB));
		end
		if (idx == ST_DIVB_FIN) o.t1 = div_fin(a.dv0);
		return o;
	endfunction

	ctx_t ctx_s [NSTG];
	logic [NSTG-1:0] vld_q;
	ctx_t ctx_in;
	logic advance;
	out_item_t res_d;
	word_t w, lim;
	out_item_t obuf_q [2];
	logic obuf_wr_q, obuf_rd_q;
	logic [1:0] obuf_cnt_q;
	logic obuf_push, obuf_pop;

	assign advance = !vld_q[NSTG-1] || (obuf_cnt_q != 2'd2);
	assign job_pop = advance && !job_empty;
	assign obuf_push = advance && vld_q[NSTG-1];
	assign obuf_pop = pop && !empty;
	assign empty = (obuf_cnt_q == 2'd0);
	assign result = obuf_q[obuf_rd_q];
	assign lim = word_t'({1'b0, cfg.angular_rate_limit});

	always_comb begin
		ctx_in = '0;
		ctx_in.d = job.d;
		ctx_in.c = job.c;
		ctx_in.dcs = job.dcs;
		ctx_in.vx = job.vx;
		ctx_in.vy = job.vy;
		ctx_in.lin = job.lin;
		ctx_in.e = job.e;
		ctx_in.rev = job.rev;
	end

	// final sum, clamp and singular override
	always_comb begin
		w = sat34(sx34(ctx_s[NSTG-1].t1) + sx34(ctx_s[NSTG-1].ui));
		if (w > lim) w = lim;
		if (w < -lim) w = -lim;
		res_d.angular_rate = ctx_s[NSTG-1].sing ? '0 : w;
		res_d.linear_speed = ctx_s[NSTG-1].lin;
		res_d.status = ctx_s[NSTG-1].sing;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (advance) begin
			vld_q <= {vld_q[NSTG-2:0], !job_empty};
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ctx_s[0] <= ctx_in;
			for (int i = 1; i < NSTG; i++) ctx_s[i] <= stage_op(i - 1, ctx_s[i-1], cfg);
		end
	end

	// two-entry result queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obuf_wr_q <= 1'b0;
			obuf_rd_q <= 1'b0;
			obuf_cnt_q <= 2'd0;
		end else begin
			if (obuf_push) obuf_wr_q <= !obuf_wr_q;
			if (obuf_pop) obuf_rd_q <= !obuf_rd_q;
			if (obuf_push && !obuf_pop) obuf_cnt_q <= obuf_cnt_q + 2'd1;
			else if (obuf_pop && !obuf_push) obuf_cnt_q <= obuf_cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (obuf_push) obuf_q[obuf_wr_q] <= res_d;
	end

`ifndef NO_ASSERTIONS
	a_obuf_bound: assert property (@(posedge clk) disable iff (!arst_n)
		obuf_cnt_q != 2'd3) else $error("result queue overflow");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[NSTG-1] && !advance |=> vld_q[NSTG-1]) else $error("stalled beat lost");
	a_rate_limit: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.angular_rate <= lim && result.angular_rate >= -lim))
		else $error("angular rate beyond limit");
	a_singular_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.status |-> result.angular_rate == '0)
		else $error("singular beat with nonzero rate");
`endif

endmodule

// File: sv/unicycle_path_following_law.sv
// Unicycle path-following law: takes one sample per clock while full is low
// and returns one result per sample, in order. The latency is set by the
// square root of the measured speed (32 stages, one result bit each) and by
// two chained levels of 48-stage restoring dividers for the quotients; all
// of it is pipelined, so the sustained rate is one beat per cycle when
// nothing stalls. Samples are classified in the front stage and wait in a
// four-deep queue; results wait in a two-entry queue; the queues absorb
// stalls on either side until they fill. Configuration writes are taken
// at any time (cfg_ready is always high) but belong only to an idle block. A
// result with status 1 marks 1-dc not positive; its angular rate is zero.
module unicycle_path_following_law import upf_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input in_item_t sample,
	output logic empty,
	input logic pop,
	output out_item_t result,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [2:0] cfg_index,
	input logic [31:0] cfg_data
);

	cfg_t cfg_q;
	logic job_push, job_full, job_pop, job_empty;
	job_t job_wr, job_rd;

	assign cfg_ready = 1'b1;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_cubic <= 31'd65536;
			cfg_q.gain_square_triple <= 31'd196608;
			cfg_q.angular_rate_limit <= 31'd65536;
			cfg_q.target_speed <= 31'd65536;
			cfg_q.reverse_mode <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_GAIN_CUBIC: cfg_q.gain_cubic <= cfg_data[30:0];
				REG_GAIN_SQUARE_TRIPLE: cfg_q.gain_square_triple <= cfg_data[30:0];
				REG_ANGULAR_RATE_LIMIT: cfg_q.angular_rate_limit <= cfg_data[30:0];
				REG_TARGET_SPEED: cfg_q.target_speed <= cfg_data[30:0];
				REG_REVERSE_MODE: cfg_q.reverse_mode <= cfg_data[0];
				default: ;
			endcase
		end
	end

	upf_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.sample(sample),
		.cfg(cfg_q),
		.job_push(job_push),
		.job_full(job_full),
		.job(job_wr)
	);

	upf_job_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(job_push),
		.full(job_full),
		.wr_job(job_wr),
		.pop(job_pop),
		.empty(job_empty),
		.rd_job(job_rd)
	);

	upf_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.job_empty(job_empty),
		.job(job_rd),
		.job_pop(job_pop),
		.empty(empty),
		.pop(pop),
		.result(result)
	);

endmodule

// File: dv/tb_unicycle_path_following_law.sv
module tb_unicycle_path_following_law;
	import upf_pkg::*;

	localparam longint SMAX = 64'sd2147483647;
	localparam longint SMIN = -64'sd2147483648;
	localparam int DRAIN_CYCLES = 300;

	// Predicts the law and holds the results still owed by the block
	class law_scoreboard;
		logic [30:0] k_cubic = 31'd65536;
		logic [30:0] k_square3 = 31'd196608;
		logic [30:0] rate_lim = 31'd65536;
		logic [30:0] speed_tgt = 31'd65536;
		bit backwards = 0;
		out_item_t owed[$];
		int errors = 0;

		function void set_reg(cfg_reg_e idx, logic [31:0] data);
			case (idx)
				REG_GAIN_CUBIC: k_cubic = data[30:0];
				REG_GAIN_SQUARE_TRIPLE: k_square3 = data[30:0];
				REG_ANGULAR_RATE_LIMIT: rate_lim = data[30:0];
				REG_TARGET_SPEED: speed_tgt = data[30:0];
				REG_REVERSE_MODE: backwards = data[0];
				default: ;
			endcase
		endfunction

		function longint clip(longint x);
			if (x > SMAX) return SMAX;
			if (x < SMIN) return SMIN;
			return x;
		endfunction

		function logic [63:0] absval(longint x);
			return x < 0 ? 64'(-x) : 64'(x);
		endfunction

		function longint signed_clip(bit neg, logic [127:0] v);
			if (neg) begin
				if (v > 128'd2147483648) return SMIN;
				return -longint'(v[63:0]);
			end
			if (v > 128'd2147483647) return SMAX;
			return longint'(v[63:0]);
		endfunction

		// Q16.16 product, rounded half away from zero
		function longint qmul(longint a, longint b);
			logic [127:0] p;
			p = 128'(absval(a)) * 128'(absval(b));
			return signed_clip((a < 0) != (b < 0), (p + 128'd32768) >> 16);
		endfunction

		// Q16.16 quotient, truncated toward zero
		function longint qdiv(longint a, longint b);
			logic [127:0] n, d;
			n = 128'(absval(a));
			d = 128'(absval(b));
			if (n == 0) return 0;
			if (d == 0) return a < 0 ? SMIN : SMAX;
			return signed_clip((a < 0) != (b < 0), (n << 16) / d);
		endfunction

		function logic [63:0] root_floor(logic [63:0] n);
			logic [63:0] res, bitv;
			res = 0;
			bitv = 64'd1 << 62;
			while (bitv > n) bitv >>= 2;
			while (bitv != 0) begin
				if (n >= res + bitv) begin
					n -= res + bitv;
					res = (res >> 1) + bitv;
				end else begin
					res >>= 1;
				end
				bitv >>= 2;
			end
			return res;
		endfunction

		function longint q30_round(logic [63:0] m, bit neg);
			longint v;
			v = longint'((m + 64'd8192) >> 14);
			return neg ? -v : v;
		endfunction

		// sine and cosine of a 16-bit turn angle by quadrant and series
		function void turn_sincos(logic [15:0] e, output longint sn, output longint cs);
			logic [63:0] q, r, x, x2, t, s0, c0;
			bit rneg;
			q = ((64'(e) + 64'd8192) >> 14) & 64'd3;
			r = (64'(e) - q * 64'd16384) & 64'hFFFF;
			rneg = r >= 64'd32768;
			if (rneg) r = (64'd65536 - r) & 64'hFFFF;
			x = (r * 64'd2 * 64'd3373259426) >> 16;
			x2 = (x * x) >> 30;
			t = 64'h4000_0000 - x2 / 72;
			t = 64'h4000_0000 - ((x2 * t) >> 30) / 42;
			t = 64'h4000_0000 - ((x2 * t) >> 30) / 20;
			t = 64'h4000_0000 - ((x2 * t) >> 30) / 6;
			s0 = (x * t) >> 30;
			t = 64'h4000_0000 - x2 / 90;
			t = 64'h4000_0000 - ((x2 * t) >> 30) / 56;
			t = 64'h4000_0000 - ((x2 * t) >> 30) / 30;
			t = 64'h4000_0000 - ((x2 * t) >> 30) / 12;
			c0 = 64'h4000_0000 - ((x2 * t) >> 30) / 2;
			case (q)
				0: begin sn = q30_round(s0, rneg); cs = q30_round(c0, 0); end
				1: begin sn = q30_round(c0, 0); cs = q30_round(s0, !rneg); end
				2: begin sn = q30_round(s0, !rneg); cs = q30_round(c0, 1); end
				default: begin sn = q30_round(c0, 1); cs = q30_round(s0, rneg); end
			endcase
		endfunction

		function out_item_t steer(in_item_t s);
			out_item_t o;
			longint d, c, dcs, vm, one_dc, w, lin, k1, k2, lim;
			longint sn, cs, tn, sn2, cs2, x2, u1, au1, u2, t1, inner;
			logic [63:0] vxm, vym, f;
			logic [15:0] e;
			d = s.lateral_error;
			c = s.path_curvature;
			dcs = s.curvature_slope;
			k1 = k_cubic;
			k2 = k_square3;
			lim = rate_lim;
			e = s.robot_heading - s.path_heading;
			vxm = absval(longint'(s.velocity_x));
			vym = absval(longint'(s.velocity_y));
			vm = clip(longint'(root_floor(vxm * vxm + vym * vym)));
			if (backwards) begin
				vm = clip(-vm);
				d = clip(-d);
				e = e + 16'h8000;
			end
			w = 0;
			o.status = 0;
			one_dc = clip(64'sd65536 - qmul(d, c));
			if (one_dc <= 0) begin
				o.status = 1;
			end else begin
				turn_sincos(e, sn, cs);
				tn = qdiv(sn, cs);
				sn2 = qmul(sn, sn);
				cs2 = qmul(cs, cs);
				x2 = qmul(one_dc, tn);
				u1 = qdiv(qmul(vm, cs), one_dc);
				au1 = u1 < 0 ? clip(-u1) : u1;
				u2 = clip(-qmul(qmul(k1, u1), d) - qmul(qmul(k2, au1), x2));
				t1 = qdiv(qmul(u2, cs2), one_dc);
				inner = clip(qmul(c, clip(64'sd65536 + sn2))
					+ qdiv(qmul(qmul(d, dcs), qmul(sn, cs)), one_dc));
				w = clip(t1 + qmul(u1, inner));
				if (w > lim) w = lim;
				if (w < -lim) w = -lim;
			end
			f = 64'(s.speed_factor);
			if (f > 64'd65536) f = 64'd65536;
			lin = clip(longint'((64'(speed_tgt) * f + 64'd32768) >> 16));
			if (backwards) lin = -lin;
			o.angular_rate = word_t'(w);
			o.linear_speed = word_t'(lin);
			return o;
		endfunction

		function void note_sample(in_item_t s);
			owed = {owed, steer(s)};
		endfunction

		function void check_result(out_item_t got);
			out_item_t exp_r;
			if (owed.size() == 0) begin
				$error("result with nothing outstanding: %h", got);
				errors++;
				return;
			end
			exp_r = owed.pop_front();
			if (got.angular_rate !== exp_r.angular_rate) begin
				$error("angular_rate expected %0d got %0d", exp_r.angular_rate,
					got.angular_rate);
				errors++;
			end
			if (got.linear_speed !== exp_r.linear_speed) begin
				$error("linear_speed expected %0d got %0d", exp_r.linear_speed,
					got.linear_speed);
				errors++;
			end
			if (got.status !== exp_r.status) begin
				$error("status expected %0d got %0d", exp_r.status, got.status);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic push = 0;
	logic full;
	in_item_t sample = '0;
	logic empty;
	logic pop = 0;
	out_item_t result;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [2:0] cfg_index = 3'd0;
	logic [31:0] cfg_data = '0;

	law_scoreboard sb = new();
	int send_idle = 13;
	int recv_idle = 51;
	int sent = 0;

	unicycle_path_following_law DUT (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .sample(sample),
		.empty(empty), .pop(pop), .result(result), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// receiver stalls
	always @(posedge clk) begin
		pop <= ($urandom_range(99) >= recv_idle);
	end

	// beat monitor for both queue sides
	always @(posedge clk) begin
		if (arst_n && push && !full) sb.note_sample(sample);
		if (arst_n && pop && !empty) sb.check_result(result);
	end

	task automatic send(in_item_t s);
		bit took;
		while ($urandom_range(99) < send_idle) begin
			push <= 0;
			@(posedge clk);
		end
		push <= 1;
		sample <= s;
		do begin
			@(negedge clk);
			took = !full;
			@(posedge clk);
		end while (!took);
		sent++;
	endtask

	task automatic write_reg(cfg_reg_e idx, logic [31:0] data);
		bit took;
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		do begin
			@(negedge clk);
			took = cfg_ready;
			@(posedge clk);
		end while (!took);
		sb.set_reg(idx, data);
		cfg_valid <= 0;
	endtask

	// hold the sender until every result is back, then let the pipe settle
	task automatic drain();
		push <= 0;
		@(posedge clk);
		while (sb.owed.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_word();
		case ($urandom_range(4))
			0: return $urandom;
			1: return 32'($urandom_range(131072)) - 32'd65536;
			2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return 32'($urandom_range(1048576)) - 32'd524288;
		endcase
	endfunction

	function automatic logic [31:0] pick_gain();
		case ($urandom_range(3))
			0: return 32'd0;
			1: return {1'($urandom_range(1)), 31'h7FFF_FFFF};
			2: return $urandom;
			default: return $urandom_range(262144);
		endcase
	endfunction

	function automatic in_item_t rand_sample();
		in_item_t s;
		s.lateral_error = pick_word();
		s.path_heading = 16'($urandom);
		s.robot_heading = 16'($urandom);
		s.path_curvature = pick_word();
		s.curvature_slope = pick_word();
		s.velocity_x = pick_word();
		s.velocity_y = pick_word();
		s.speed_factor = $urandom_range(3) == 0 ? 17'($urandom) : 17'($urandom_range(65536));
		return s;
	endfunction

	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		in_item_t s;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: field extremes and the named corner cases at reset config
		s = '0;
		send(s);
		s.lateral_error = 32'h7FFF_FFFF; s.path_curvature = 32'h8000_0000;
		s.velocity_x = 32'h8000_0000; s.velocity_y = 32'h8000_0000;
		s.speed_factor = 17'h1FFFF;
		send(s);
		s = '0; s.lateral_error = 32'h8000_0000; s.path_curvature = 32'h7FFF_FFFF;
		s.curvature_slope = 32'h8000_0000; s.speed_factor = 17'd65536;
		send(s);
		// singular: d*c exactly one, then above one
		s = '0; s.lateral_error = 32'h0001_0000; s.path_curvature = 32'h0001_0000;
		s.velocity_x = 32'h0002_0000;
		send(s);
		s.lateral_error = 32'h0002_0000;
		send(s);
		// heading errors at every eighth of a turn, quarter, half and three-quarter turns among them
		for (int k = 0; k < 8; k++) begin
			s = '0;
			s.lateral_error = 32'h0000_8000;
			s.path_curvature = 32'h0000_4000;
			s.curvature_slope = 32'hFFFF_0000;
			s.velocity_x = 32'h0001_8000;
			s.velocity_y = 32'hFFFF_0000;
			s.path_heading = 16'hFFFF - 16'(k);
			s.robot_heading = s.path_heading + 16'(k * 8192);
			s.speed_factor = 17'(k * 8192);
			send(s);
		end
		s = '0; s.path_heading = 16'hFFFF; s.robot_heading = 16'hFFFF;
		s.curvature_slope = 32'h7FFF_FFFF; s.velocity_y = 32'h7FFF_FFFF;
		send(s);
		drain();

		// random phases, each under a fresh setting
		for (int ph = 0; ph < 10; ph++) begin
			if (ph == 0) begin
				write_reg(REG_GAIN_CUBIC, 32'h7FFF_FFFF);
				write_reg(REG_GAIN_SQUARE_TRIPLE, 32'hFFFF_FFFF);
				write_reg(REG_ANGULAR_RATE_LIMIT, 32'h7FFF_FFFF);
				write_reg(REG_TARGET_SPEED, 32'h7FFF_FFFF);
				write_reg(REG_REVERSE_MODE, 32'd1);
			end else if (ph == 1) begin
				write_reg(REG_GAIN_CUBIC, 32'd0);
				write_reg(REG_GAIN_SQUARE_TRIPLE, 32'd0);
				write_reg(REG_ANGULAR_RATE_LIMIT, 32'd0);
				write_reg(REG_TARGET_SPEED, 32'd0);
				write_reg(REG_REVERSE_MODE, 32'hFFFF_FFFE);
			end else begin
				write_reg(REG_GAIN_CUBIC, pick_gain());
				write_reg(REG_GAIN_SQUARE_TRIPLE, pick_gain());
				write_reg(REG_ANGULAR_RATE_LIMIT, pick_gain());
				write_reg(REG_TARGET_SPEED, pick_gain());
				write_reg(REG_REVERSE_MODE, 32'(ph % 2));
			end
			for (int n = 0; n < 123; n++) begin
				if (sent < 430) begin
					send_idle = 13; recv_idle = 51;
				end else if (sent < 850) begin
					send_idle = 51; recv_idle = 13;
				end else begin
					send_idle = 0; recv_idle = 0;
				end
				send(rand_sample());
			end
			drain();
		end

		if (sb.errors == 0 && sb.owed.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// File: sim.f
sv/upf_pkg.sv
sv/upf_job_fifo.sv
sv/upf_front.sv
sv/upf_back.sv
sv/unicycle_path_following_law.sv
dv/tb_unicycle_path_following_law.sv
